### rtl/sitoa_pkg.sv
// Shared types, constants and the BCD shift-and-add step used by the
// signed integer to decimal ASCII converter. No dependencies.
package sitoa_pkg;

  localparam int VALUE_W        = 64;
  localparam int NUM_DIGITS     = 19;
  localparam int DIGIT_W        = 4;
  localparam int BCD_W          = NUM_DIGITS * DIGIT_W;
  localparam int IDX_W          = 5;
  localparam int CHAR_W         = 8;
  localparam int STAGE_BITS_DEF = 4;

  localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0]  CHAR_NINE  = 8'h39;
  localparam logic [DIGIT_W-1:0] ADJ_MIN    = 4'd5;
  localparam logic [DIGIT_W-1:0] ADJ_ADD    = 4'd3;

  // One item in flight through the conversion pipeline.
  typedef struct packed {
    logic               valid;
    logic               neg;
    logic [VALUE_W-1:0] mag;
    logic [BCD_W-1:0]   bcd;
  } dd_bus_t;

  // One double-dabble step: correct every digit of five or more, then shift
  // the next binary bit in at the bottom.
  function automatic logic [BCD_W-1:0] dabble_step(input logic [BCD_W-1:0] bcd,
                                                   input logic bit_in);
    logic [BCD_W-1:0] adj;
    adj = bcd;
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (adj[d*DIGIT_W +: DIGIT_W] >= ADJ_MIN) begin
        adj[d*DIGIT_W +: DIGIT_W] = adj[d*DIGIT_W +: DIGIT_W] + ADJ_ADD;
      end
    end
    return {adj[BCD_W-2:0], bit_in};
  endfunction

endpackage

### rtl/sitoa_dd_stage.sv
// One register stage of the binary to BCD pipeline, shifting STAGE_BITS
// magnitude bits into the digit register. Depends on sitoa_pkg.
module sitoa_dd_stage
  import sitoa_pkg::*;
#(
  parameter int STAGE_BITS = STAGE_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    en,
  input  dd_bus_t in_bus,
  output dd_bus_t out_bus
);

  logic               valid_r;
  logic               neg_r;
  logic [VALUE_W-1:0] mag_r;
  logic [BCD_W-1:0]   bcd_r;
  logic [VALUE_W-1:0] mag_nxt;
  logic [BCD_W-1:0]   bcd_nxt;

  always_comb begin
    mag_nxt = in_bus.mag;
    bcd_nxt = in_bus.bcd;
    for (int s = 0; s < STAGE_BITS; s++) begin
      bcd_nxt = dabble_step(bcd_nxt, mag_nxt[VALUE_W-1]);
      mag_nxt = {mag_nxt[VALUE_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_r <= in_bus.neg;
      mag_r <= mag_nxt;
      bcd_r <= bcd_nxt;
    end
  end

  assign out_bus = '{valid: valid_r, neg: neg_r, mag: mag_r, bcd: bcd_r};

endmodule

### rtl/sitoa_emit.sv
// Character serializer: takes a converted item (sign and BCD digits) and
// sends its text one character per cycle through an output register,
// while the output is not stalled. Depends on sitoa_pkg.
module sitoa_emit
  import sitoa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  dd_bus_t           in_bus,
  output logic              take,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CHAR_W-1:0] out_character,
  output logic              out_last
);

  logic              busy_r, busy_nxt;
  logic              neg_pend_r, neg_pend_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [BCD_W-1:0]  bcd_r, bcd_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] out_char_r, out_char_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_free;
  logic [IDX_W-1:0]  msd;
  logic [DIGIT_W-1:0] cur_digit;

  // Position of the most significant nonzero digit; zero prints one digit.
  always_comb begin
    msd = '0;
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (in_bus.bcd[d*DIGIT_W +: DIGIT_W] != '0) begin
        msd = IDX_W'(d);
      end
    end
  end

  assign cur_digit = bcd_r[idx_r*DIGIT_W +: DIGIT_W];
  assign out_free  = !out_valid_r || !out_stall;
  assign take      = !busy_r;

  always_comb begin
    busy_nxt      = busy_r;
    neg_pend_nxt  = neg_pend_r;
    idx_nxt       = idx_r;
    bcd_nxt       = bcd_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    if (out_free) begin
      out_valid_nxt = 1'b0;
    end
    if (busy_r && out_free) begin
      out_valid_nxt = 1'b1;
      if (neg_pend_r) begin
        out_char_nxt = CHAR_MINUS;
        out_last_nxt = 1'b0;
        neg_pend_nxt = 1'b0;
      end else begin
        out_char_nxt = CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, cur_digit};
        out_last_nxt = (idx_r == '0);
        if (idx_r == '0) begin
          busy_nxt = 1'b0;
        end else begin
          idx_nxt = idx_r - 1'b1;
        end
      end
    end
    if (!busy_r && in_bus.valid) begin
      busy_nxt     = 1'b1;
      neg_pend_nxt = in_bus.neg;
      idx_nxt      = msd;
      bcd_nxt      = in_bus.bcd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      neg_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      neg_pend_r  <= neg_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    bcd_r      <= bcd_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

endmodule

### rtl/signed_int_to_decimal_ascii.sv
// Top level of the signed 64-bit integer to decimal ASCII converter.
// Depends on sitoa_pkg, sitoa_dd_stage and sitoa_emit.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_stall   in_value[63:0] signed
//   out_     output     out_valid / out_stall out_character[7:0], out_last
//
// An item passes a magnitude register and 64/STAGE_BITS double-dabble stages
// (16 at the default), then the serializer, which sends one character per
// cycle while the output is not stalled. The serializer takes a new item only
// after it has sent the last character of the one before; it sets the rate.
// Reset is synchronous and clears only valid and control bits. A stall on
// the output holds the output register; the pipeline advances as a whole and
// stalls the input while its last stage waits for the serializer.
module signed_int_to_decimal_ascii
  import sitoa_pkg::*;
#(
  parameter int STAGE_BITS = STAGE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [VALUE_W-1:0] in_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [CHAR_W-1:0]         out_character,
  output logic                      out_last
);

  localparam int NUM_STAGES = VALUE_W / STAGE_BITS;

  logic               en;
  logic               take;
  logic               v0_r;
  logic               neg0_r;
  logic [VALUE_W-1:0] mag0_r;
  logic [VALUE_W-1:0] raw;
  logic [VALUE_W-1:0] mag_nxt;
  dd_bus_t            bus [NUM_STAGES+1];

  // Two's complement negate in unsigned arithmetic, so the most negative
  // value gives its true magnitude.
  assign raw     = in_value;
  assign mag_nxt = raw[VALUE_W-1] ? (~raw + 1'b1) : raw;

  assign en       = !bus[NUM_STAGES].valid || take;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg0_r <= raw[VALUE_W-1];
      mag0_r <= mag_nxt;
    end
  end

  assign bus[0] = '{valid: v0_r, neg: neg0_r, mag: mag0_r, bcd: '0};

  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
    sitoa_dd_stage #(
      .STAGE_BITS(STAGE_BITS)
    ) u_stage (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .in_bus (bus[g]),
      .out_bus(bus[g+1])
    );
  end

  sitoa_emit u_emit (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_bus       (bus[NUM_STAGES]),
    .take         (take),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_character(out_character),
    .out_last     (out_last)
  );

  // A minus sign is never the final character of a number.
  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_character == CHAR_MINUS) |-> !out_last)
    else $error("minus sign flagged as last character");

  // Every character sent is a minus sign or a decimal digit.
  a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_character == CHAR_MINUS ||
                   (out_character >= CHAR_ZERO && out_character <= CHAR_NINE)))
    else $error("illegal character sent");

  // An item waiting at the end of the pipeline is not dropped.
  a_tail_held: assert property (@(posedge clk) disable iff (!rst_n)
    (bus[NUM_STAGES].valid && !take) |=> bus[NUM_STAGES].valid)
    else $error("pipeline tail item lost while serializer busy");

endmodule
